// File: sv/kic_pkg.sv
// shared types and constants for the keypad integer calculator
`default_nettype none

package kic_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int OUT_WIDTH         = 32;
  localparam int KEY_WIDTH         = 8;
  localparam int OPC_WIDTH         = 3;

  localparam logic [KEY_WIDTH-1:0] KEY_CLEAR  = 8'h2A;  // '*'
  localparam logic [KEY_WIDTH-1:0] KEY_EQUALS = 8'h3D;  // '='
  localparam logic [KEY_WIDTH-1:0] KEY_PLUS   = 8'h2B;  // '+'
  localparam logic [KEY_WIDTH-1:0] KEY_MINUS  = 8'h2D;  // '-'
  localparam logic [KEY_WIDTH-1:0] KEY_TIMES  = 8'h78;  // 'x'
  localparam logic [KEY_WIDTH-1:0] KEY_DIVIDE = 8'h2F;  // '/'
  localparam logic [KEY_WIDTH-1:0] KEY_ZERO   = 8'h30;  // '0'
  localparam logic [KEY_WIDTH-1:0] KEY_NINE   = 8'h39;  // '9'

  typedef enum logic [OPC_WIDTH-1:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KC_CLEAR,
    KC_OPERATOR,
    KC_DIGIT,
    KC_EQUALS,
    KC_OTHER
  } key_class_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_FINISH,
    ST_PUBLISH
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic load_op;
    logic load_digit;
    logic eq_simple;
    logic iter_start;
    logic iter_step;
    logic iter_finish;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    key_class_e key_class;
    logic       use_unit;
    logic       iter_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: sv/kic_ctrl.sv
// controller state machine: sequences key handling, the shift unit and output loading
`default_nettype none

module kic_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  kic_pkg::dp_status_t status_i,
  output kic_pkg::ctrl_cmd_t  cmd_o
);

  kic_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kic_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign accept   = in_valid_i && (state_q == kic_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      kic_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = kic_pkg::ST_PUBLISH;
          unique case (status_i.key_class)
            kic_pkg::KC_CLEAR:    cmd_o.clear      = 1'b1;
            kic_pkg::KC_OPERATOR: cmd_o.load_op    = 1'b1;
            kic_pkg::KC_DIGIT:    cmd_o.load_digit = 1'b1;
            kic_pkg::KC_EQUALS: begin
              if (status_i.use_unit) begin
                cmd_o.iter_start = 1'b1;
                state_d          = kic_pkg::ST_ITER;
              end else begin
                cmd_o.eq_simple = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      kic_pkg::ST_ITER: begin
        cmd_o.iter_step = 1'b1;
        if (status_i.iter_last) begin
          state_d = kic_pkg::ST_FINISH;
        end
      end
      kic_pkg::ST_FINISH: begin
        cmd_o.iter_finish = 1'b1;
        state_d           = kic_pkg::ST_PUBLISH;
      end
      kic_pkg::ST_PUBLISH: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = kic_pkg::ST_IDLE;
        end
      end
      default: state_d = kic_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o  = (state_q != kic_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: sv/kic_datapath.sv
// datapath: operand registers, shift-add multiplier / restoring divider, output registers
`default_nettype none

module kic_datapath #(
  parameter int OPERAND_WIDTH = kic_pkg::OPERAND_WIDTH_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire  [kic_pkg::KEY_WIDTH-1:0]          key_code_i,
  input  kic_pkg::ctrl_cmd_t                     cmd_i,
  output kic_pkg::dp_status_t                    status_o,
  output logic signed [kic_pkg::OUT_WIDTH-1:0]   first_operand_o,
  output logic signed [kic_pkg::OUT_WIDTH-1:0]   second_operand_o,
  output logic        [kic_pkg::OPC_WIDTH-1:0]   operator_code_o,
  output logic signed [kic_pkg::OUT_WIDTH-1:0]   answer_o,
  output logic                                   answer_ready_o,
  output logic                                   divide_error_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int OW = kic_pkg::OUT_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]    first_q, first_d;
  logic [W-1:0]    second_q, second_d;
  kic_pkg::op_e    op_q, op_d;
  logic            entering_q, entering_d;
  logic [W-1:0]    result_q, result_d;
  logic            eq_seen_q, eq_seen_d;
  logic            err_q, err_d;
  logic [CW-1:0]   count_q, count_d;

  // shared iteration registers: accumulator/remainder, multiplicand/divisor,
  // multiplier/quotient
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    mcand_q, mcand_d;
  logic [W-1:0]    mplier_q, mplier_d;

  logic signed [OW-1:0] first_out_q, second_out_q, answer_out_q;
  logic [kic_pkg::OPC_WIDTH-1:0] opc_out_q;
  logic            ready_out_q, err_out_q;

  kic_pkg::key_class_e key_class;
  kic_pkg::op_e        key_op;
  logic [W-1:0]        digit;
  logic [W-1:0]        base;
  logic [W-1:0]        base_next;
  logic                div_fault;
  logic                neg_quot;
  logic [W-1:0]        first_mag, second_mag;
  logic [W:0]          rem_sh, rem_diff;
  logic [W-1:0]        simple_result;
  logic signed [OW-1:0] first_ext, second_ext, result_ext;

  // key decode
  always_comb begin
    key_op = kic_pkg::OP_NONE;
    unique case (key_code_i)
      kic_pkg::KEY_CLEAR:  key_class = kic_pkg::KC_CLEAR;
      kic_pkg::KEY_EQUALS: key_class = kic_pkg::KC_EQUALS;
      kic_pkg::KEY_PLUS: begin
        key_class = kic_pkg::KC_OPERATOR;
        key_op    = kic_pkg::OP_ADD;
      end
      kic_pkg::KEY_MINUS: begin
        key_class = kic_pkg::KC_OPERATOR;
        key_op    = kic_pkg::OP_SUB;
      end
      kic_pkg::KEY_TIMES: begin
        key_class = kic_pkg::KC_OPERATOR;
        key_op    = kic_pkg::OP_MUL;
      end
      kic_pkg::KEY_DIVIDE: begin
        key_class = kic_pkg::KC_OPERATOR;
        key_op    = kic_pkg::OP_DIV;
      end
      default: begin
        if (key_code_i >= kic_pkg::KEY_ZERO && key_code_i <= kic_pkg::KEY_NINE) begin
          key_class = kic_pkg::KC_DIGIT;
        end else begin
          key_class = kic_pkg::KC_OTHER;
        end
      end
    endcase
  end

  // value*10 + digit as two shifted adds
  assign digit     = {{(W-4){1'b0}}, key_code_i[3:0]};
  assign base      = entering_q ? second_q : first_q;
  assign base_next = {base[W-4:0], 3'b000} + {base[W-2:0], 1'b0} + digit;

  assign div_fault  = (second_q == '0) || ($signed(first_q) < $signed(second_q));
  assign neg_quot   = first_q[W-1] ^ second_q[W-1];
  assign first_mag  = first_q[W-1] ? (~first_q + 1'b1) : first_q;
  assign second_mag = second_q[W-1] ? (~second_q + 1'b1) : second_q;

  assign rem_sh   = {acc_q, mplier_q[W-1]};
  assign rem_diff = rem_sh - {1'b0, mcand_q};

  always_comb begin
    case (op_q)
      kic_pkg::OP_ADD: simple_result = first_q + second_q;
      kic_pkg::OP_SUB: simple_result = first_q - second_q;
      default:         simple_result = '0;
    endcase
  end

  always_comb begin
    first_d    = first_q;
    second_d   = second_q;
    op_d       = op_q;
    entering_d = entering_q;
    result_d   = result_q;
    eq_seen_d  = eq_seen_q;
    err_d      = err_q;
    count_d    = count_q;
    acc_d      = acc_q;
    mcand_d    = mcand_q;
    mplier_d   = mplier_q;

    if (cmd_i.clear) begin
      first_d    = '0;
      second_d   = '0;
      op_d       = kic_pkg::OP_NONE;
      entering_d = 1'b0;
      result_d   = '0;
      eq_seen_d  = 1'b0;
      err_d      = 1'b0;
    end
    if (cmd_i.load_op) begin
      op_d       = key_op;
      entering_d = 1'b1;
    end
    if (cmd_i.load_digit) begin
      if (entering_q) begin
        second_d = base_next;
      end else begin
        first_d = base_next;
      end
    end
    if (cmd_i.eq_simple) begin
      result_d  = simple_result;
      eq_seen_d = 1'b1;
      if (op_q == kic_pkg::OP_DIV) begin
        err_d = 1'b1;
      end
    end
    if (cmd_i.iter_start) begin
      count_d = CW'(W);
      acc_d   = '0;
      if (op_q == kic_pkg::OP_MUL) begin
        mcand_d  = first_q;
        mplier_d = second_q;
      end else begin
        mcand_d  = second_mag;
        mplier_d = first_mag;
      end
    end
    if (cmd_i.iter_step) begin
      count_d = count_q - 1'b1;
      if (op_q == kic_pkg::OP_MUL) begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[W-1:1]};
      end else if (!rem_diff[W]) begin
        acc_d    = rem_diff[W-1:0];
        mplier_d = {mplier_q[W-2:0], 1'b1};
      end else begin
        acc_d    = rem_sh[W-1:0];
        mplier_d = {mplier_q[W-2:0], 1'b0};
      end
    end
    if (cmd_i.iter_finish) begin
      eq_seen_d = 1'b1;
      if (op_q == kic_pkg::OP_MUL) begin
        result_d = acc_q;
      end else begin
        result_d = neg_quot ? (~mplier_q + 1'b1) : mplier_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= '0;
      second_q   <= '0;
      op_q       <= kic_pkg::OP_NONE;
      entering_q <= 1'b0;
      result_q   <= '0;
      eq_seen_q  <= 1'b0;
      err_q      <= 1'b0;
      count_q    <= '0;
    end else begin
      first_q    <= first_d;
      second_q   <= second_d;
      op_q       <= op_d;
      entering_q <= entering_d;
      result_q   <= result_d;
      eq_seen_q  <= eq_seen_d;
      err_q      <= err_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  // operands and result to the fixed output width
  generate
    if (W >= OW) begin : g_trunc
      assign first_ext  = first_q[OW-1:0];
      assign second_ext = second_q[OW-1:0];
      assign result_ext = result_q[OW-1:0];
    end else begin : g_sext
      assign first_ext  = {{(OW-W){first_q[W-1]}}, first_q};
      assign second_ext = {{(OW-W){second_q[W-1]}}, second_q};
      assign result_ext = {{(OW-W){result_q[W-1]}}, result_q};
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      first_out_q  <= first_ext;
      second_out_q <= second_ext;
      opc_out_q    <= op_q;
      answer_out_q <= result_ext;
      ready_out_q  <= eq_seen_q;
      err_out_q    <= err_q;
    end
  end

  assign status_o.key_class = key_class;
  assign status_o.use_unit  = (op_q == kic_pkg::OP_MUL) ||
                              ((op_q == kic_pkg::OP_DIV) && !div_fault);
  assign status_o.iter_last = (count_q == CW'(1));

  assign first_operand_o  = first_out_q;
  assign second_operand_o = second_out_q;
  assign operator_code_o  = opc_out_q;
  assign answer_o         = answer_out_q;
  assign answer_ready_o   = ready_out_q;
  assign divide_error_o   = err_out_q;

endmodule

`default_nettype wire

// File: sv/keypad_integer_calculator.sv
// keypad four-function integer calculator, top level
// result: registered in the publish state once the output is free; '=' with multiply or a valid
//   divide first runs the iterate and finish states (one-bit-per-cycle shift-add / restoring divide)
// throughput: one key in flight; the next key is taken only after its result is loaded
// reset (async, active low) clears operands, operator, answer and both flags; output registers are not reset
`default_nettype none

module keypad_integer_calculator #(
  parameter int OPERAND_WIDTH = kic_pkg::OPERAND_WIDTH_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire  [kic_pkg::KEY_WIDTH-1:0]          key_code_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [kic_pkg::OUT_WIDTH-1:0]   first_operand_o,
  output logic signed [kic_pkg::OUT_WIDTH-1:0]   second_operand_o,
  output logic        [kic_pkg::OPC_WIDTH-1:0]   operator_code_o,
  output logic signed [kic_pkg::OUT_WIDTH-1:0]   answer_o,
  output logic                                   answer_ready_o,
  output logic                                   divide_error_o
);

  kic_pkg::ctrl_cmd_t  cmd;
  kic_pkg::dp_status_t status;

  kic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kic_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_code_i       (key_code_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .first_operand_o  (first_operand_o),
    .second_operand_o (second_operand_o),
    .operator_code_o  (operator_code_o),
    .answer_o         (answer_o),
    .answer_ready_o   (answer_ready_o),
    .divide_error_o   (divide_error_o)
  );

endmodule

`default_nettype wire

// File: sv/kic_checker.sv
// port-level checker for the keypad integer calculator, bound to the top level
`default_nettype none

module kic_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_valid_i,
  input wire                               in_stall_o,
  input wire                               out_valid_o,
  input wire                               out_stall_i,
  input wire [kic_pkg::OUT_WIDTH-1:0]      answer_o,
  input wire                               answer_ready_o,
  input wire                               divide_error_o
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one key in flight: the input side closes right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before result was loaded");

  // answer stays zero until equals
  a_answer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !answer_ready_o |-> answer_o == '0)
    else $error("nonzero answer without equals");

  // a divide error can only come from equals
  a_err_needs_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |-> answer_ready_o)
    else $error("divide error flagged without equals");

endmodule

bind keypad_integer_calculator kic_checker u_kic_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .answer_o       (answer_o),
  .answer_ready_o (answer_ready_o),
  .divide_error_o (divide_error_o)
);

`default_nettype wire
